### hw/rtl/tmq_pkg.sv
// Package for the timed mailbox queue: payload structs, opcodes, status codes,
// flag values and sequencer states. No dependencies.
package tmq_pkg;

	localparam int TMQ_ENTRIES = 16;

	localparam logic [15:0] NO_SLOT      = 16'hFFFF;
	localparam logic [1:0]  FLAG_PENDING = 2'h3;
	localparam logic [1:0]  FLAG_LAST    = 2'h2;
	localparam logic [1:0]  FLAG_STOPPED = 2'h0;

	localparam logic [2:0] OP_POST    = 3'd0;
	localparam logic [2:0] OP_GET     = 3'd1;
	localparam logic [2:0] OP_GET_CMD = 3'd2;
	localparam logic [2:0] OP_STOP    = 3'd3;
	localparam logic [2:0] OP_TICK    = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ERROR = 2'd1;
	localparam logic [1:0] ST_NONE  = 2'd2;

	typedef struct packed {
		logic [2:0]  operation;
		logic [7:0]  box_id;
		logic [7:0]  reply_box;
		logic [7:0]  command;
		logic [15:0] item_handle;
		logic [15:0] latency;
		logic [7:0]  repeat_count;
		logic [15:0] target_slot;
		logic [15:0] current_slot;
		logic [15:0] tick_amount;
	} tmq_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  out_command;
		logic [7:0]  out_reply_box;
		logic [15:0] out_item;
		logic        flag_write;
		logic [15:0] flag_item;
		logic [1:0]  flag_value;
	} tmq_out_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FREE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} tmq_state_t;

endpackage

### hw/rtl/timed_mailbox_queue.sv
// Timed mailbox queue top level: message table, order list and scan sequencer.
// Depends on tmq_pkg.
//
//  channel | dir | payload   | handshake
//  in      | in  | tmq_in_t  | in_valid / in_ready
//  out     | out | tmq_out_t | out_valid / out_ready
//
// Tick and unknown ops go straight to the done state. Post scans for a free
// entry, one per cycle. Get and stop walk the order list one position per cycle
// until a match or the end of the list, then on a match close the gap one
// position per cycle.
// A shared compare unit evaluates one list position a cycle.
// Reset clears used bits, list length and time; no clearing pass.
// in_ready is low while an item is in work or its result waits.
module timed_mailbox_queue
	import tmq_pkg::*;
#(
	parameter int ENTRIES = TMQ_ENTRIES
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  tmq_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output tmq_out_t out_data
);

	localparam int IW = $clog2(ENTRIES);
	localparam int LW = $clog2(ENTRIES + 1);
	localparam logic [LW-1:0] FULL = LW'(ENTRIES);

	tmq_state_t state_q, state_d;
	tmq_in_t    req_q;
	tmq_out_t   res_q;
	logic       out_valid_q;

	logic [ENTRIES-1:0] used_q;
	logic [7:0]  box_mem   [ENTRIES];
	logic [7:0]  reply_mem [ENTRIES];
	logic [7:0]  cmd_mem   [ENTRIES];
	logic [15:0] item_mem  [ENTRIES];
	logic [31:0] stamp_mem [ENTRIES];
	logic [15:0] delay_mem [ENTRIES];
	logic [7:0]  rep_mem   [ENTRIES];
	logic [15:0] slot_mem  [ENTRIES];
	logic [IW-1:0] order_q [ENTRIES];
	logic [LW-1:0] len_q;
	logic [31:0]   time_q;

	logic [LW-1:0] pos_q;
	logic [IW-1:0] hit_idx_q;
	logic          requeue_q;

	// Shared compare unit: evaluate the entry at the current list position
	logic [IW-1:0] cur_idx;
	logic [31:0]   age;
	logic          match, ready_hit, counted;
	logic          scan_end;

	always_comb begin
		cur_idx   = order_q[pos_q[IW-1:0]];
		age       = time_q - stamp_mem[cur_idx];
		scan_end  = (pos_q >= len_q);
		counted   = 1'b1;
		ready_hit = 1'b0;
		if (slot_mem[cur_idx] == NO_SLOT) begin
			if (delay_mem[cur_idx] == 16'd0) begin
				ready_hit = 1'b1;
				counted   = 1'b0;
			end else begin
				ready_hit = age > {16'd0, delay_mem[cur_idx]};
			end
		end else begin
			ready_hit = slot_mem[cur_idx] == req_q.current_slot;
		end
		if (req_q.operation == OP_STOP) begin
			match = item_mem[cur_idx] == req_q.item_handle;
		end else begin
			match = (box_mem[cur_idx] == req_q.box_id)
				&& (req_q.operation != OP_GET_CMD || cmd_mem[cur_idx] == req_q.command)
				&& ready_hit;
		end
	end

	assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					unique case (in_data.operation) inside
						OP_POST:            state_d = S_FREE;
						OP_GET, OP_GET_CMD,
						OP_STOP:            state_d = S_SCAN;
						default:            state_d = S_DONE;
					endcase
				end
			end
			S_FREE: begin
				if (req_q.item_handle == 16'd0 || len_q >= FULL
					|| !used_q[pos_q[IW-1:0]] || pos_q == LW'(ENTRIES - 1)) begin
					state_d = S_DONE;
				end
			end
			S_SCAN: begin
				if (scan_end) state_d = S_DONE;
				else if (match) state_d = S_SHIFT;
			end
			S_SHIFT: begin
				if (pos_q + LW'(1) >= len_q) state_d = S_DONE;
			end
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			used_q      <= '0;
			len_q       <= '0;
			time_q      <= '0;
			pos_q       <= '0;
			requeue_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				// Latch the beat and clear the result; reset the scan state and apply a tick
				S_IDLE: begin
					if (in_valid && in_ready) begin
						pos_q     <= '0;
						requeue_q <= 1'b0;
						if (in_data.operation == OP_TICK) begin
							time_q <= time_q + {16'd0, in_data.tick_amount};
						end
					end
				end
				// Find a free entry and store the message
				S_FREE: begin
					if (req_q.item_handle != 16'd0 && len_q < FULL
						&& !used_q[pos_q[IW-1:0]]) begin
						used_q[pos_q[IW-1:0]] <= 1'b1;
						order_q[len_q[IW-1:0]] <= pos_q[IW-1:0];
						len_q <= len_q + LW'(1);
					end else begin
						pos_q <= pos_q + LW'(1);
					end
				end
				// Walk the list; on a hit decide remove or requeue
				S_SCAN: begin
					if (!scan_end) begin
						if (match) begin
							hit_idx_q <= cur_idx;
							if (req_q.operation != OP_STOP && counted
								&& rep_mem[cur_idx] > 8'd1) begin
								requeue_q <= 1'b1;
							end else begin
								used_q[cur_idx] <= 1'b0;
							end
						end else begin
							pos_q <= pos_q + LW'(1);
						end
					end
				end
				// Close the gap one position a cycle; requeue at the tail or shorten the list
				S_SHIFT: begin
					if (pos_q + LW'(1) < len_q) begin
						order_q[pos_q[IW-1:0]] <= order_q[pos_q[IW-1:0] + IW'(1)];
						pos_q <= pos_q + LW'(1);
					end else if (requeue_q) begin
						order_q[pos_q[IW-1:0]] <= hit_idx_q;
					end else begin
						len_q <= len_q - LW'(1);
					end
				end
				S_DONE:  out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// Payload and table storage
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && in_ready) begin
			req_q <= in_data;
			res_q <= '0;
		end
		if (state_q == S_FREE) begin
			if (req_q.item_handle == 16'd0 || len_q >= FULL) begin
				res_q.status <= ST_ERROR;
			end else if (!used_q[pos_q[IW-1:0]]) begin
				box_mem[pos_q[IW-1:0]]   <= req_q.box_id;
				reply_mem[pos_q[IW-1:0]] <= req_q.reply_box;
				cmd_mem[pos_q[IW-1:0]]   <= req_q.command;
				item_mem[pos_q[IW-1:0]]  <= req_q.item_handle;
				stamp_mem[pos_q[IW-1:0]] <= time_q;
				delay_mem[pos_q[IW-1:0]] <= req_q.latency;
				rep_mem[pos_q[IW-1:0]]   <= req_q.repeat_count;
				slot_mem[pos_q[IW-1:0]]  <= req_q.target_slot;
				if (req_q.latency != 16'd0) begin
					res_q.flag_write <= 1'b1;
					res_q.flag_item  <= req_q.item_handle;
					res_q.flag_value <= FLAG_PENDING;
				end
			end else if (pos_q == LW'(ENTRIES - 1)) begin
				res_q.status <= ST_ERROR;
			end
		end
		if (state_q == S_SCAN) begin
			if (scan_end) begin
				res_q.status <= ST_NONE;
			end else if (match) begin
				if (req_q.operation == OP_STOP) begin
					res_q.flag_write <= 1'b1;
					res_q.flag_item  <= req_q.item_handle;
					res_q.flag_value <= FLAG_STOPPED;
				end else begin
					res_q.out_command   <= cmd_mem[cur_idx];
					res_q.out_reply_box <= reply_mem[cur_idx];
					res_q.out_item      <= item_mem[cur_idx];
					if (counted && rep_mem[cur_idx] <= 8'd1) begin
						res_q.flag_write <= 1'b1;
						res_q.flag_item  <= item_mem[cur_idx];
						res_q.flag_value <= FLAG_LAST;
					end else if (counted) begin
						rep_mem[cur_idx]   <= rep_mem[cur_idx] - 8'd1;
						stamp_mem[cur_idx] <= time_q;
					end
				end
			end
		end
	end

endmodule

### bench/tb_timed_mailbox_queue.sv
// Self-checking bench for timed_mailbox_queue: directed and random message traffic,
// predicted against a behavioral mailbox table. Depends on tmq_pkg and the RTL.
module tb_timed_mailbox_queue;
	timeunit 1ns;
	timeprecision 1ps;
	import tmq_pkg::*;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	tmq_in_t in_data;
	tmq_out_t out_data;

	timed_mailbox_queue u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// mailbox table shadow
	logic        mb_used [TMQ_ENTRIES];
	logic [7:0]  mb_box [TMQ_ENTRIES];
	logic [7:0]  mb_reply [TMQ_ENTRIES];
	logic [7:0]  mb_cmd [TMQ_ENTRIES];
	logic [15:0] mb_item [TMQ_ENTRIES];
	logic [31:0] mb_stamp [TMQ_ENTRIES];
	logic [15:0] mb_delay [TMQ_ENTRIES];
	logic [7:0]  mb_rep [TMQ_ENTRIES];
	logic [15:0] mb_slot [TMQ_ENTRIES];
	int          mb_order[$];
	logic [31:0] mb_now;

	tmq_out_t delivery_q[$];
	int errors;
	bit quiet;
	logic [15:0] handle_pool[$];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("tb_timed_mailbox_queue NOT OK");
		$finish;
	end

	// compute the result of one item and advance the shadow table
	function automatic tmq_out_t mailbox_step(tmq_in_t t);
		tmq_out_t r;
		int idx, p;
		bit ok, timed;
		r = '0;
		case (t.operation)
			OP_POST: begin
				idx = -1;
				for (int i = 0; i < TMQ_ENTRIES; i++)
					if (!mb_used[i] && idx < 0) idx = i;
				if (t.item_handle == 0 || idx < 0) begin
					r.status = ST_ERROR;
				end else begin
					mb_used[idx] = 1; mb_box[idx] = t.box_id; mb_reply[idx] = t.reply_box;
					mb_cmd[idx] = t.command; mb_item[idx] = t.item_handle;
					mb_stamp[idx] = mb_now; mb_delay[idx] = t.latency;
					mb_rep[idx] = t.repeat_count; mb_slot[idx] = t.target_slot;
					if (t.latency != 0) begin
						r.flag_write = 1; r.flag_item = t.item_handle; r.flag_value = FLAG_PENDING;
					end
					mb_order.push_back(idx);
				end
			end
			OP_GET, OP_GET_CMD: begin
				r.status = ST_NONE;
				for (p = 0; p < mb_order.size(); p++) begin
					idx = mb_order[p];
					ok = 0; timed = 1;
					if (mb_box[idx] != t.box_id) continue;
					if (t.operation == OP_GET_CMD && mb_cmd[idx] != t.command) continue;
					if (mb_slot[idx] == NO_SLOT) begin
						if (mb_delay[idx] == 0) begin
							ok = 1; timed = 0;
						end else if (mb_now - mb_stamp[idx] > {16'h0, mb_delay[idx]}) ok = 1;
					end else if (mb_slot[idx] == t.current_slot) ok = 1;
					if (!ok) continue;
					r.status = ST_OK; r.out_command = mb_cmd[idx];
					r.out_reply_box = mb_reply[idx]; r.out_item = mb_item[idx];
					mb_order.delete(p);
					if (!timed) begin
						mb_used[idx] = 0;
					end else if (mb_rep[idx] <= 1) begin
						r.flag_write = 1; r.flag_item = mb_item[idx]; r.flag_value = FLAG_LAST;
						mb_used[idx] = 0;
					end else begin
						mb_order.push_back(idx);
						mb_rep[idx]--;
						mb_stamp[idx] = mb_now;
					end
					break;
				end
			end
			OP_STOP: begin
				r.status = ST_NONE;
				for (p = 0; p < mb_order.size(); p++) begin
					idx = mb_order[p];
					if (mb_item[idx] == t.item_handle) begin
						r.status = ST_OK; r.flag_write = 1;
						r.flag_item = t.item_handle; r.flag_value = FLAG_STOPPED;
						mb_order.delete(p);
						mb_used[idx] = 0;
						break;
					end
				end
			end
			OP_TICK: mb_now += {16'h0, t.tick_amount};
			default: ;
		endcase
		return r;
	endfunction

	// send one beat, predicting on acceptance; valid drops only for an idle burst
	task automatic send_msg(tmq_in_t t);
		int gap;
		if (!quiet && $urandom_range(3) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= t;
		do @(posedge clk); while (!in_ready);
		delivery_q.push_back(mailbox_step(t));
		if (t.item_handle != 0) handle_pool.push_back(t.item_handle);
		if (handle_pool.size() > 40) void'(handle_pool.pop_front());
	endtask

	function automatic tmq_in_t blank_msg(logic [2:0] op);
		tmq_in_t t;
		t = '0;
		t.operation = op;
		t.target_slot = NO_SLOT;
		return t;
	endfunction

	// receiver with random stall bursts
	initial begin
		int n;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(3) == 0) begin
				out_ready <= 0;
				n = $urandom_range(1, 10);
				repeat (n) @(posedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
		end
	end

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (delivery_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_data);
				errors++;
			end else begin
				tmq_out_t e;
				e = delivery_q.pop_front();
				if (e.status != out_data.status)
					$display("%0t: status exp %0d got %0d", $time, e.status, out_data.status);
				if (e.out_command != out_data.out_command)
					$display("%0t: out_command exp %h got %h", $time, e.out_command,
						out_data.out_command);
				if (e.out_reply_box != out_data.out_reply_box)
					$display("%0t: out_reply_box exp %h got %h", $time, e.out_reply_box,
						out_data.out_reply_box);
				if (e.out_item != out_data.out_item)
					$display("%0t: out_item exp %h got %h", $time, e.out_item, out_data.out_item);
				if (e.flag_write != out_data.flag_write)
					$display("%0t: flag_write exp %b got %b", $time, e.flag_write,
						out_data.flag_write);
				if (e.flag_item != out_data.flag_item)
					$display("%0t: flag_item exp %h got %h", $time, e.flag_item, out_data.flag_item);
				if (e.flag_value != out_data.flag_value)
					$display("%0t: flag_value exp %0d got %0d", $time, e.flag_value,
						out_data.flag_value);
				if (e !== out_data) errors++;
			end
		end
	end

	task automatic test_directed();
		tmq_in_t t;
		// null handle, immediate post and get
		t = blank_msg(OP_POST); send_msg(t);
		t = blank_msg(OP_POST); t.box_id = 8'hFF; t.reply_box = 8'hFF; t.command = 8'hFF;
		t.item_handle = 16'hFFFF; send_msg(t);
		t = blank_msg(OP_GET_CMD); t.box_id = 8'hFF; t.command = 8'h00; send_msg(t);
		t.command = 8'hFF; send_msg(t);
		t = blank_msg(OP_GET); send_msg(t);
		// delayed with repeats, max latency
		t = blank_msg(OP_POST); t.box_id = 1; t.item_handle = 16'h0001; t.latency = 16'hFFFF;
		t.repeat_count = 8'hFF; send_msg(t);
		t = blank_msg(OP_POST); t.box_id = 1; t.item_handle = 2; t.latency = 1; t.repeat_count = 2;
		send_msg(t);
		t = blank_msg(OP_GET); t.box_id = 1; send_msg(t);
		t = blank_msg(OP_TICK); t.tick_amount = 16'hFFFF; send_msg(t);
		t = blank_msg(OP_GET); t.box_id = 1; send_msg(t); send_msg(t); send_msg(t);
		// slot delivery, latency ignored
		t = blank_msg(OP_POST); t.box_id = 2; t.item_handle = 3; t.latency = 100;
		t.target_slot = 16'hFFFE; send_msg(t);
		t = blank_msg(OP_GET); t.box_id = 2; t.current_slot = 16'hFFFE; send_msg(t);
		// stop hit and miss, unknown op
		t = blank_msg(OP_STOP); t.item_handle = 1; send_msg(t); send_msg(t);
		t = blank_msg(3'd7); t = ~t; t.operation = 3'd5; send_msg(t);
		// fill table to overflow
		for (int i = 0; i < TMQ_ENTRIES + 1; i++) begin
			t = blank_msg(OP_POST); t.box_id = 9; t.item_handle = 16'h100 + i; send_msg(t);
		end
		for (int i = 0; i < TMQ_ENTRIES; i++) begin
			t = blank_msg(OP_GET); t.box_id = 9; send_msg(t);
		end
	endtask

	task automatic test_random(int count);
		tmq_in_t t;
		int k;
		for (int n = 0; n < count; n++) begin
			t = tmq_in_t'({$urandom, $urandom, $urandom, $urandom});
			t.box_id = $urandom_range(0, 3) == 0 ? t.box_id : 8'($urandom_range(0, 3));
			t.command = $urandom_range(0, 3) == 0 ? t.command : 8'($urandom_range(0, 2));
			t.current_slot = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 16'hFFFE))
				: 16'($urandom_range(0, 3));
			if (t.current_slot == NO_SLOT) t.current_slot = 0;
			k = $urandom_range(0, 99);
			if (k < 30) begin
				t.operation = OP_POST;
				if ($urandom_range(0, 2) == 0) t.target_slot = 16'($urandom_range(0, 3));
				else t.target_slot = NO_SLOT;
				if ($urandom_range(0, 1)) t.latency = 0;
				else if ($urandom_range(0, 3) != 0) t.latency = 16'($urandom_range(1, 40));
				t.repeat_count = $urandom_range(0, 3) == 0 ? t.repeat_count
					: 8'($urandom_range(0, 3));
				if ($urandom_range(0, 30) == 0) t.item_handle = 0;
			end else if (k < 70) begin
				t.operation = $urandom_range(0, 1) ? OP_GET : OP_GET_CMD;
			end else if (k < 80) begin
				t.operation = OP_STOP;
				if (handle_pool.size() > 0 && $urandom_range(0, 3) != 0)
					t.item_handle = handle_pool[$urandom_range(0, handle_pool.size() - 1)];
			end else if (k < 97) begin
				t.operation = OP_TICK;
				if ($urandom_range(0, 7) != 0) t.tick_amount = 16'($urandom_range(0, 30));
			end else begin
				t.operation = 3'($urandom_range(5, 7));
			end
			send_msg(t);
		end
	endtask

	initial begin
		int w;
		errors = 0; quiet = 0;
		in_valid = 0; in_data = '0; arst_n = 0;
		for (int i = 0; i < TMQ_ENTRIES; i++) mb_used[i] = 0;
		mb_now = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random(1200);
		quiet = 1;
		test_random(200);
		in_valid <= 0;
		w = 0;
		while (delivery_q.size() != 0 && w < 100000) begin
			@(posedge clk);
			w++;
		end
		repeat (100) @(posedge clk);
		if (errors == 0 && delivery_q.size() == 0)
			$display("tb_timed_mailbox_queue OK");
		else
			$display("tb_timed_mailbox_queue NOT OK");
		$finish;
	end
endmodule
